[hdl/sdtq_pkg.sv]
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int DL_W   = 64;
    localparam int TAG_W  = 16;
    localparam int WAIT_W = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [DATA_W-1:0] FREQ_RESET = 32'd62500000;

    // register index, taken from paddr[2]
    localparam logic REG_FREQ = 1'b0;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic KIND_SCHED   = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic [DL_W-1:0]   a;
        logic [DL_W-1:0]   b;
        logic              sub;
        logic [WAIT_W-1:0] mul_a;
        logic [WAIT_W-1:0] mul_b;
    } alu_req_t;

    typedef struct packed {
        logic [DL_W-1:0] sum;
        logic            carry;    // on sub: a >= b
        logic [DL_W-1:0] prod;
    } alu_rsp_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL      = 9'b000000010,
        ST_ADD      = 9'b000000100,
        ST_INS_RD   = 9'b000001000,
        ST_INS_CMP  = 9'b000010000,
        ST_WR_NEW   = 9'b000100000,
        ST_HEAD_RD  = 9'b001000000,
        ST_HEAD_CMP = 9'b010000000,
        ST_SCHED    = 9'b100000000
    } state_t;

endpackage

[hdl/sdtq_alu.sv]
// ----------------------------------------------------------------------------
// sdtq_alu
// Shared 64-bit add/subtract-compare unit and 32x32 multiplier.
// ----------------------------------------------------------------------------
module sdtq_alu (
    input  sdtq_pkg::alu_req_t req,
    output sdtq_pkg::alu_rsp_t rsp
);

    logic [sdtq_pkg::DL_W:0] total;

    always_comb begin
        total = {1'b0, req.a}
              + {1'b0, req.b ^ {sdtq_pkg::DL_W{req.sub}}}
              + {{sdtq_pkg::DL_W{1'b0}}, req.sub};
        rsp.sum   = total[sdtq_pkg::DL_W-1:0];
        rsp.carry = total[sdtq_pkg::DL_W];
        rsp.prod  = {{sdtq_pkg::WAIT_W{1'b0}}, req.mul_a}
                  * {{sdtq_pkg::WAIT_W{1'b0}}, req.mul_b};
    end

endmodule

[hdl/sdtq_mem.sv]
// ----------------------------------------------------------------------------
// sdtq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdtq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  sdtq_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output sdtq_pkg::entry_t rd_data
);

    sdtq_pkg::entry_t mem [DEPTH];
    sdtq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sorted_deadline_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Sorted timer queue: adds timers by deadline, pops expired ones in order,
// and reports the compare delta of the head timer after every item.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  s_       | s_valid/s_ready, operation, now, wait, tag | in
//  m_       | m_valid/m_ready, kind, tag, delta, flags   | out
//  apb      | psel/penable/pwrite/paddr/pwdata/prdata    | cfg
//
//  One item at a time. Add: the new deadline is compared with the entries from
//  the tail (one registered read and one compare each); a full queue drops it.
//  Check: pops the expired entries from the head, one after another.
//  Output beats wait in an output register; m_ready low stalls the sequencer
//  only when it has a new beat to deliver.
//  Synchronous active-low reset empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [sdtq_pkg::DL_W-1:0]     s_now,
    input  logic [sdtq_pkg::WAIT_W-1:0]   s_wait_seconds,
    input  logic [sdtq_pkg::TAG_W-1:0]    s_tag,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [sdtq_pkg::TAG_W-1:0]    m_expired_tag,
    output logic [31:0]                   m_compare_delta,
    output logic                          m_irq_enable,
    output logic                          m_full_drop,
    output logic                          m_last,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdtq_pkg::ADDR_W-1:0]   paddr,
    input  logic [sdtq_pkg::DATA_W-1:0]   pwdata,
    output logic [sdtq_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd,
                                           input logic [AW-1:0] lg);
        logic [AW:0] s;
        s = {1'b0, hd} + {1'b0, lg};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    // control state
    sdtq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic           drop_reg, drop_next;
    logic           m_valid_reg;
    logic [sdtq_pkg::DATA_W-1:0] freq_reg;

    // item payload
    logic                        op_reg;
    logic [sdtq_pkg::DL_W-1:0]   now_reg;
    logic [sdtq_pkg::WAIT_W-1:0] wait_reg;
    logic [sdtq_pkg::TAG_W-1:0]  tag_reg;
    logic [sdtq_pkg::DL_W-1:0]   prod_reg;
    logic [sdtq_pkg::DL_W-1:0]   dl_reg;

    // output beat
    logic                        m_kind_reg;
    logic [sdtq_pkg::TAG_W-1:0]  m_tag_reg;
    logic [31:0]                 m_delta_reg;
    logic                        m_irq_reg;
    logic                        m_drop_reg;
    logic                        m_last_reg;

    logic                        emit;
    logic                        emit_kind;
    logic [sdtq_pkg::TAG_W-1:0]  emit_tag;
    logic [31:0]                 emit_delta;
    logic                        emit_irq;
    logic                        emit_drop;
    logic                        out_free;
    logic                        in_fire;
    logic                        cfg_wr;
    logic                        pop;

    sdtq_pkg::alu_req_t alu_req;
    sdtq_pkg::alu_rsp_t alu_rsp;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    sdtq_pkg::entry_t  wr_data, rd_data;

    sdtq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    sdtq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == sdtq_pkg::ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == sdtq_pkg::REG_FREQ);
    assign prdata = (paddr[2] == sdtq_pkg::REG_FREQ) ? freq_reg : '0;

    // sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        drop_next  = drop_reg;
        pop        = 1'b0;

        alu_req.a     = now_reg;
        alu_req.b     = prod_reg;
        alu_req.sub   = 1'b0;
        alu_req.mul_a = wait_reg;
        alu_req.mul_b = freq_reg;

        wr_en   = 1'b0;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = head_reg;

        emit       = 1'b0;
        emit_kind  = sdtq_pkg::KIND_SCHED;
        emit_tag   = '0;
        emit_delta = '0;
        emit_irq   = 1'b0;
        emit_drop  = 1'b0;

        case (state_reg)
            sdtq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    drop_next  = 1'b0;
                    state_next = (s_operation == sdtq_pkg::OP_ADD) ?
                                 sdtq_pkg::ST_MUL : sdtq_pkg::ST_HEAD_RD;
                end
            end
            sdtq_pkg::ST_MUL: begin
                state_next = sdtq_pkg::ST_ADD;
            end
            sdtq_pkg::ST_ADD: begin
                // deadline = now + product, latched into dl_reg
                if (count_reg == DEPTH_C) begin
                    drop_next  = 1'b1;
                    state_next = sdtq_pkg::ST_HEAD_RD;
                end else begin
                    idx_next   = count_reg[AW-1:0];
                    state_next = (count_reg == '0) ?
                                 sdtq_pkg::ST_WR_NEW : sdtq_pkg::ST_INS_RD;
                end
            end
            sdtq_pkg::ST_INS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_reg, idx_reg - AW'(1));
                state_next = sdtq_pkg::ST_INS_CMP;
            end
            sdtq_pkg::ST_INS_CMP: begin
                alu_req.a   = dl_reg;
                alu_req.b   = rd_data.deadline;
                alu_req.sub = 1'b1;
                if (alu_req.sub && !alu_rsp.carry) begin
                    // entry is later than the new deadline: move it back one
                    wr_en    = 1'b1;
                    idx_next = idx_reg - AW'(1);
                    state_next = (idx_reg == AW'(1)) ?
                                 sdtq_pkg::ST_WR_NEW : sdtq_pkg::ST_INS_RD;
                end else begin
                    state_next = sdtq_pkg::ST_WR_NEW;
                end
            end
            sdtq_pkg::ST_WR_NEW: begin
                wr_en      = 1'b1;
                wr_data    = '{deadline: dl_reg, tag: tag_reg};
                count_next = count_reg + CW'(1);
                state_next = sdtq_pkg::ST_HEAD_RD;
            end
            sdtq_pkg::ST_HEAD_RD: begin
                if (count_reg == '0) begin
                    state_next = sdtq_pkg::ST_SCHED;
                end else begin
                    rd_en      = 1'b1;
                    state_next = sdtq_pkg::ST_HEAD_CMP;
                end
            end
            sdtq_pkg::ST_HEAD_CMP: begin
                alu_req.a   = now_reg;
                alu_req.b   = rd_data.deadline;
                alu_req.sub = 1'b1;
                if (op_reg == sdtq_pkg::OP_CHECK && alu_rsp.carry) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        emit_kind  = sdtq_pkg::KIND_EXPIRED;
                        emit_tag   = rd_data.tag;
                        pop        = 1'b1;
                        head_next  = phys(head_reg, AW'(1));
                        count_next = count_reg - CW'(1);
                        state_next = sdtq_pkg::ST_HEAD_RD;
                    end
                end else begin
                    state_next = sdtq_pkg::ST_SCHED;
                end
            end
            sdtq_pkg::ST_SCHED: begin
                alu_req.a   = rd_data.deadline;
                alu_req.b   = now_reg;
                alu_req.sub = 1'b1;
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = sdtq_pkg::KIND_SCHED;
                    emit_irq   = (count_reg != '0);
                    emit_delta = emit_irq ? alu_rsp.sum[31:0] : '0;
                    emit_drop  = drop_reg;
                    state_next = sdtq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sdtq_pkg::ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            idx_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            freq_reg    <= sdtq_pkg::FREQ_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                freq_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= s_operation;
            now_reg  <= s_now;
            wait_reg <= s_wait_seconds;
            tag_reg  <= s_tag;
        end
        if (state_reg == sdtq_pkg::ST_MUL) begin
            prod_reg <= alu_rsp.prod;
        end
        if (state_reg == sdtq_pkg::ST_ADD) begin
            dl_reg <= alu_rsp.sum;
        end
        if (emit) begin
            m_kind_reg  <= emit_kind;
            m_tag_reg   <= emit_tag;
            m_delta_reg <= emit_delta;
            m_irq_reg   <= emit_irq;
            m_drop_reg  <= emit_drop;
            m_last_reg  <= (emit_kind == sdtq_pkg::KIND_SCHED);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_expired_tag   = m_tag_reg;
    assign m_compare_delta = m_delta_reg;
    assign m_irq_enable    = m_irq_reg;
    assign m_full_drop     = m_drop_reg;
    assign m_last          = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("ready right after accepting an item");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not decrement the count");

    a_irq_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == sdtq_pkg::KIND_SCHED && m_irq_reg
        |-> count_reg != '0)
        else $error("irq enable reported with an empty queue");

endmodule
